[hw/rtl/assert_macros.svh]
// Assertion macros for the verification monitor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/fulp_pkg.sv]
// Package: command and status codes, field widths and register defaults of the pool.
package fulp_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned REQ_W    = 16;
    localparam int unsigned UNIT_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned USIZE_W  = 16;
    localparam int unsigned NUNITS_W = 9;

    // Units reachable through the 8-bit unit index.
    localparam int unsigned IDX_LIMIT = 256;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELINK = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RESET     = 2'd3;

    localparam logic REG_UNIT_BYTES = 1'b0;
    localparam logic REG_UNIT_COUNT = 1'b1;

    localparam logic [USIZE_W-1:0]  UNIT_BYTES_RESET = 16'd64;
    localparam logic [NUNITS_W-1:0] UNIT_COUNT_RESET = 9'd256;

endpackage

[hw/rtl/fulp_store.sv]
// Next-pointer store: one write port, one read port, registered read data.
module fulp_store #(
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned ADDR_W = 8,
    parameter int unsigned DATA_W = 9
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/fixed_unit_free_list_pool_top.sv]
// Top level: fixed-unit pool allocator with a linked free list in a next-pointer RAM.
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       s_tdata: cmd, request_bytes, free_unit
//  m_*       out  m_tvalid / m_tready       m_tdata: status, unit_id
//  apb       in   psel, penable, pwrite     paddr, pwdata -> unit_bytes, unit_count; prdata
//
//  One command at a time. Allocate, free and refused commands pass through the
//  accept cycle (head check, RAM read of the head's next pointer, or the free's write)
//  and then retire into the output register. Relink writes one RAM entry per cycle,
//  for min(unit_count, depth) entries; the single RAM port pair sets this pace.
//  A word waiting in the output register does not block the next accept; a command
//  that finishes while the register is still full waits in DONE until it drains.
//  After rst_n the free list is empty until a relink or free command; no clearing pass runs.
module fixed_unit_free_list_pool_top #(
    parameter int unsigned MAX_UNITS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [1:0] cmd, [17:2] request_bytes, [25:18] free_unit
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] status, [9:2] unit_id
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // RAM depth: units beyond the 8-bit index can never be linked or freed.
    localparam int unsigned DEPTH =
        (MAX_UNITS < fulp_pkg::IDX_LIMIT) ? MAX_UNITS : fulp_pkg::IDX_LIMIT;
    localparam int unsigned IDX_W = $clog2(DEPTH);
    // Pointers hold a unit index or the empty mark (MAX_UNITS).
    localparam int unsigned PTR_W = $clog2(MAX_UNITS + 1);
    localparam logic [PTR_W-1:0] EMPTY_MARK = PTR_W'(MAX_UNITS);
    localparam logic [fulp_pkg::NUNITS_W-1:0] DEPTH_CNT = fulp_pkg::NUNITS_W'(DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_ALLOC, ST_RELINK, ST_DONE} state_t;

    state_t                              state_reg;
    logic [PTR_W-1:0]                    head_reg;
    logic [IDX_W-1:0]                    cnt_reg;
    logic [IDX_W-1:0]                    last_reg;
    logic [fulp_pkg::STATUS_W-1:0]       res_status_reg;
    logic [fulp_pkg::UNIT_W-1:0]         res_index_reg;
    logic                                m_tvalid_reg;
    logic [fulp_pkg::STATUS_W-1:0]       m_status_reg;
    logic [fulp_pkg::UNIT_W-1:0]         m_index_reg;
    logic [fulp_pkg::USIZE_W-1:0]        unit_bytes_reg;
    logic [fulp_pkg::NUNITS_W-1:0]       unit_count_reg;

    // input word fields
    logic [fulp_pkg::CMD_W-1:0]  in_cmd;
    logic [fulp_pkg::REQ_W-1:0]  in_req;
    logic [fulp_pkg::UNIT_W-1:0] in_unit;

    assign in_cmd  = s_tdata[1:0];
    assign in_req  = s_tdata[17:2];
    assign in_unit = s_tdata[25:18];

    logic accept;
    logic slot_free;
    logic out_load;
    logic unit_ok;
    logic head_empty;
    logic [fulp_pkg::NUNITS_W-1:0] link_cnt;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign slot_free  = !m_tvalid_reg || m_tready;
    // a finished command moves into the output register
    assign out_load   = slot_free && ((state_reg == ST_ALLOC) || (state_reg == ST_DONE));
    assign unit_ok    = 32'(in_unit) < 32'(MAX_UNITS);
    assign head_empty = head_reg >= EMPTY_MARK;
    // relink covers min(unit_count, depth) units
    assign link_cnt   = (unit_count_reg > DEPTH_CNT) ? DEPTH_CNT : unit_count_reg;

    // next-pointer RAM
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [PTR_W-1:0]  mem_wdata;
    logic [PTR_W-1:0]  mem_rdata;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        if (accept && (in_cmd == fulp_pkg::CMD_FREE) && unit_ok)
        begin
            // push: freed unit points at the old head
            mem_we    = 1'b1;
            mem_waddr = in_unit[IDX_W-1:0];
            mem_wdata = head_reg;
        end
        else if (state_reg == ST_RELINK)
        begin
            mem_we    = 1'b1;
            mem_waddr = cnt_reg;
            mem_wdata = (cnt_reg == last_reg) ? EMPTY_MARK : (PTR_W'(cnt_reg) + PTR_W'(1));
        end
    end

    // Read port always follows the head; in ST_ALLOC the data is the popped unit's link.
    fulp_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (PTR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (head_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    // command sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= EMPTY_MARK;
            cnt_reg        <= '0;
            last_reg       <= '0;
            res_status_reg <= fulp_pkg::STATUS_OK;
            res_index_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
            m_status_reg   <= fulp_pkg::STATUS_OK;
            m_index_reg    <= '0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        unique case (in_cmd)
                            fulp_pkg::CMD_ALLOC:
                            begin
                                // size check wins over the empty check
                                if (in_req > unit_bytes_reg)
                                begin
                                    res_status_reg <= fulp_pkg::STATUS_TOO_LARGE;
                                    res_index_reg  <= '0;
                                    state_reg      <= ST_DONE;
                                end
                                else if (head_empty)
                                begin
                                    res_status_reg <= fulp_pkg::STATUS_EMPTY;
                                    res_index_reg  <= '0;
                                    state_reg      <= ST_DONE;
                                end
                                else
                                begin
                                    res_index_reg <= fulp_pkg::UNIT_W'(head_reg);
                                    state_reg     <= ST_ALLOC;
                                end
                            end
                            fulp_pkg::CMD_FREE:
                            begin
                                // no double-free check; out-of-range index is a no-op
                                if (unit_ok)
                                begin
                                    head_reg <= PTR_W'(in_unit);
                                end
                                res_status_reg <= fulp_pkg::STATUS_OK;
                                res_index_reg  <= '0;
                                state_reg      <= ST_DONE;
                            end
                            fulp_pkg::CMD_RELINK:
                            begin
                                res_index_reg <= '0;
                                if (link_cnt == '0)
                                begin
                                    head_reg       <= EMPTY_MARK;
                                    res_status_reg <= fulp_pkg::STATUS_RESET;
                                    state_reg      <= ST_DONE;
                                end
                                else
                                begin
                                    head_reg  <= '0;
                                    cnt_reg   <= '0;
                                    last_reg  <= IDX_W'(link_cnt - 9'd1);
                                    state_reg <= ST_RELINK;
                                end
                            end
                            default:
                            begin
                                // unused code: no state change
                                res_status_reg <= fulp_pkg::STATUS_OK;
                                res_index_reg  <= '0;
                                state_reg      <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_ALLOC:
                begin
                    // pop: head takes the popped unit's link
                    head_reg <= mem_rdata;
                    if (slot_free)
                    begin
                        m_status_reg <= fulp_pkg::STATUS_OK;
                        m_index_reg  <= res_index_reg;
                        state_reg    <= ST_IDLE;
                    end
                    else
                    begin
                        res_status_reg <= fulp_pkg::STATUS_OK;
                        state_reg      <= ST_DONE;
                    end
                end
                ST_RELINK:
                begin
                    if (cnt_reg == last_reg)
                    begin
                        res_status_reg <= fulp_pkg::STATUS_RESET;
                        state_reg      <= ST_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + IDX_W'(1);
                    end
                end
                ST_DONE:
                begin
                    if (slot_free)
                    begin
                        m_status_reg <= res_status_reg;
                        m_index_reg  <= res_index_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_index_reg, m_status_reg};

    // register port: index is paddr[2], byte offset ignored
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_bytes_reg <= fulp_pkg::UNIT_BYTES_RESET;
            unit_count_reg <= fulp_pkg::UNIT_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == fulp_pkg::REG_UNIT_BYTES)
            begin
                unit_bytes_reg <= pwdata[15:0];
            end
            else
            begin
                unit_count_reg <= pwdata[8:0];
            end
        end
    end

    assign prdata = (paddr[2] == fulp_pkg::REG_UNIT_COUNT) ? {23'b0, unit_count_reg}
                                                           : {16'b0, unit_bytes_reg};

endmodule

[hw/rtl/fulp_monitor.sv]
// Port-level assertion monitor for the pool allocator, bound to the top level.
`include "assert_macros.svh"

module fulp_monitor (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    logic [fulp_pkg::STATUS_W-1:0] out_status;
    logic [fulp_pkg::UNIT_W-1:0]   out_id;
    logic                          sel_bytes;
    logic                          wr_bytes;

    assign out_status = m_tdata[1:0];
    assign out_id     = m_tdata[9:2];
    assign sel_bytes  = (paddr[2] == fulp_pkg::REG_UNIT_BYTES);
    assign wr_bytes   = psel && penable && pwrite && sel_bytes;

    // stalled output word holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one command in flight: no accept in the cycle after an accept
    `ASSERT_NEXT(a_one_cmd, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // a word with a status other than OK carries a zero unit index
    `ASSERT_SAME(a_idx_zero, clk, rst_n, m_tvalid && (out_status != fulp_pkg::STATUS_OK), out_id == '0)

    // unit byte limit reads back what was written
    `ASSERT_NEXT(a_cfg_readback, clk, rst_n, wr_bytes, !sel_bytes || (prdata[15:0] == $past(pwdata[15:0])))

endmodule

bind fixed_unit_free_list_pool_top fulp_monitor u_fulp_monitor (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
